[sv/assert_macros.svh]
// Assertion helpers shared by the table engine modules.
// Each macro expects clk and arst_n to exist in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// A condition that must hold together with a consequence in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[sv/ste_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table engine package
// Shared types and constants for the controller, datapath and top level.
// ----------------------------------------------------------------------------
package ste_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic               hit;
		logic               overflow;
		logic               is_empty;
		logic [6:0]         entry_count;
		logic signed [31:0] smallest;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COMPARE,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic load;
		logic cmp_en;
		logic ins_en;
		logic rem_en;
		logic hit;
		logic overflow;
		logic report;
	} ctrl_t;

	typedef struct packed {
		logic [1:0] op;
		logic       full;
		logic       found;
	} status_t;

endpackage

[sv/sorted_table_engine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted table engine
// Bounded ascending table of signed values with insert, remove and search.
//
//   Channel  Signals             Direction  Transfer
//   command  start, busy, cmd    in         start high while busy is low
//   result   done, result        out        every cycle done is high
//
// Each command runs a compare state, which checks the operand against every
// stored entry at once, then an update state, which shifts the table and
// updates the count. The result shows in the cycle after the update; a new
// command is taken in the update cycle, so commands can follow back to back.
// Reset empties the table; no clearing pass is needed.
// The result port has no backpressure and must be taken when done is high.
// ----------------------------------------------------------------------------
module sorted_table_engine_unit #(
	parameter int CAPACITY = ste_pkg::CAPACITY_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ste_pkg::cmd_t  cmd,
	output logic           done,
	output ste_pkg::rsp_t  result
);

	ste_pkg::ctrl_t   ctrl;
	ste_pkg::status_t status;

	ste_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	ste_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.ctrl   (ctrl),
		.status (status),
		.done   (done),
		.result (result)
	);

endmodule

[sv/ste_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Sorted table engine controller
// Sequences the compare and update cycles and decides each command's outcome.
// ----------------------------------------------------------------------------
module ste_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ste_pkg::status_t  status,
	output logic              busy,
	output ste_pkg::ctrl_t    ctrl
);

	ste_pkg::state_t state_q;
	ste_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ste_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ste_pkg::ST_IDLE: begin
				if (start) state_d = ste_pkg::ST_COMPARE;
			end
			ste_pkg::ST_COMPARE: begin
				state_d = ste_pkg::ST_UPDATE;
			end
			ste_pkg::ST_UPDATE: begin
				state_d = start ? ste_pkg::ST_COMPARE : ste_pkg::ST_IDLE;
			end
			default: begin
				state_d = ste_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy     = (state_q == ste_pkg::ST_COMPARE);
		ctrl     = '0;
		ctrl.load = start && !busy;
		unique case (state_q)
			ste_pkg::ST_COMPARE: begin
				ctrl.cmp_en = 1'b1;
			end
			ste_pkg::ST_UPDATE: begin
				ctrl.report = 1'b1;
				case (status.op)
					ste_pkg::OP_INSERT: begin
						ctrl.ins_en   = !status.full;
						ctrl.hit      = !status.full;
						ctrl.overflow = status.full;
					end
					ste_pkg::OP_REMOVE: begin
						ctrl.rem_en = status.found;
						ctrl.hit    = status.found;
					end
					ste_pkg::OP_SEARCH: begin
						ctrl.hit = status.found;
					end
					default: begin
						ctrl.hit = 1'b0;
					end
				endcase
			end
			default: begin
				ctrl.cmp_en = 1'b0;
			end
		endcase
	end

	`ASSERT_NEXT(a_cmp_then_upd, state_q == ste_pkg::ST_COMPARE, state_q == ste_pkg::ST_UPDATE, "Compare cycle not followed by update")
	`ASSERT_SAME(a_ins_has_room, ctrl.ins_en, !status.full && !ctrl.rem_en, "Insert enabled into a full table")
	`ASSERT_SAME(a_busy_compare, busy, ctrl.cmp_en, "Busy outside a compare cycle")

endmodule

[sv/ste_datapath.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// Sorted table engine datapath
// Holds the sorted entries, compares them in parallel and shifts them in place.
// ----------------------------------------------------------------------------
module ste_datapath #(
	parameter int CAPACITY = ste_pkg::CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ste_pkg::cmd_t     cmd,
	input  ste_pkg::ctrl_t    ctrl,
	output ste_pkg::status_t  status,
	output logic              done,
	output ste_pkg::rsp_t     result
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [31:0] entry_q [CAPACITY];
	logic signed [31:0] entry_d [CAPACITY];
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_d;
	logic [1:0]         op_q;
	logic signed [31:0] value_q;
	logic [CAPACITY-1:0] le_d;
	logic [CAPACITY-1:0] ge_d;
	logic [CAPACITY-1:0] le_s1;
	logic [CAPACITY-1:0] ge_s1;
	logic               done_q;
	ste_pkg::rsp_t      result_q;
	ste_pkg::rsp_t      result_d;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			le_d[i] = (count_q > CW'(i)) && (entry_q[i] <= value_q);
			ge_d[i] = (count_q > CW'(i)) && (entry_q[i] >= value_q);
		end
	end

	assign status.op    = op_q;
	assign status.full  = (count_q == CW'(CAPACITY));
	assign status.found = |(le_s1 & ge_s1);

	always_comb begin
		entry_d = entry_q;
		if (ctrl.ins_en) begin
			entry_d[0] = le_s1[0] ? entry_q[0] : value_q;
			for (int i = 1; i < CAPACITY; i++) begin
				if (!le_s1[i]) begin
					entry_d[i] = le_s1[i-1] ? value_q : entry_q[i-1];
				end
			end
		end else if (ctrl.rem_en) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				if (ge_s1[i]) begin
					entry_d[i] = entry_q[i+1];
				end
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (ctrl.ins_en) begin
			count_d = count_q + CW'(1);
		end else if (ctrl.rem_en) begin
			count_d = count_q - CW'(1);
		end
	end

	always_comb begin
		result_d.hit         = ctrl.hit;
		result_d.overflow    = ctrl.overflow;
		result_d.is_empty    = (count_d == '0);
		result_d.entry_count = 7'(count_d);
		result_d.smallest    = (count_d == '0) ? 32'sd0 : entry_d[0];
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
		if (ctrl.load) begin
			op_q    <= cmd.op;
			value_q <= cmd.value;
		end
		if (ctrl.cmp_en) begin
			le_s1 <= le_d;
			ge_s1 <= ge_d;
		end
		if (ctrl.report) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= ctrl.report;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`ASSERT_NEXT(a_ins_count, ctrl.ins_en, count_q == $past(count_q) + CW'(1), "Insert did not grow the table by one")
	`ASSERT_ALWAYS(a_count_range, count_q <= CW'(CAPACITY), "Entry count beyond capacity")
	`ASSERT_SAME(a_sorted_head, count_q >= CW'(2), entry_q[0] <= entry_q[1], "Table head out of order")

endmodule
